// ===== rtl/stok_pkg.sv =====
package stok_pkg;

  localparam int MaxTokenLen = 1024;
  // Token length counter only ever holds up to MaxTokenLen-1
  localparam int TokLenW     = $clog2(MaxTokenLen);
  localparam int LineW       = 16;
  localparam int MaxResults  = 4;
  localparam int ResIdxW     = $clog2(MaxResults);
  localparam int ResCntW     = $clog2(MaxResults + 1);

  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharSemi   = 8'h3B;
  localparam logic [7:0] CharLBrace = 8'h7B;
  localparam logic [7:0] CharRBrace = 8'h7D;

  typedef enum logic [2:0] {
    ModeSkip,
    ModeToken,
    ModeQuoted,
    ModeLineCmt,
    ModeBlock,
    ModeStar,
    ModeSlash
  } mode_e;

  typedef enum logic [1:0] {
    KindByte,
    KindEnd,
    KindBreak,
    KindEoi
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       token_byte;
    logic             was_quoted;
    logic             too_long;
    logic [LineW-1:0] line_number;
    logic             run_last;
  } out_word_t;

endpackage

// ===== rtl/script_tokenizer.sv =====
// Script text tokenizer.
// Input channel: one word per text byte (data_byte), or a word with
// end_of_input set that flushes any pending token and ends the text.
// Output channel: a stream of result words (token byte, end of token,
// line break, end of input); run_last marks the final word that an input
// word caused. An input word may cause nothing, or up to four words.
// An accepted input word is held in the input register, decoded into the
// result buffer once the buffer is free, and offered from the buffer.
// Throughput: one input word per cycle while each causes at most one
// result and the output does not stall; a word with several results holds
// the four-entry result buffer until all of its results are taken. The
// input register and the result buffer are separate, so one input word is
// taken while results wait. A stalled output holds its word; the input
// stalls once the input register is full and the buffer cannot drain.
// Reset clears the scan mode, the token length, the overflow flag, the
// line count and marks both buffers empty. End of input returns the scan state and
// the line count to their reset values.
module script_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stok_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stok_pkg::out_word_t out_word_o
);
  import stok_pkg::*;

  localparam logic [TokLenW-1:0] LenLimit = TokLenW'(MaxTokenLen - 1);

  logic             in_full_q;
  in_word_t         in_q;
  mode_e            mode_q, mode_d;
  logic [TokLenW-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic [LineW-1:0] line_q, line_d;

  out_word_t        res_q [MaxResults];
  out_word_t        res_d [MaxResults];
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic [ResIdxW-1:0] idx_q;

  logic in_take, process, out_take, last_take, buf_free;

  assign out_valid_o = (cnt_q != '0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign last_take   = out_take && (ResCntW'(idx_q) + 1'b1 == cnt_q);
  assign buf_free    = !out_valid_o || last_take;
  assign process     = in_full_q && buf_free;
  assign in_stall_o  = in_full_q && !process;
  assign in_take     = in_valid_i && !in_stall_o;

  always_comb begin
    out_word_o          = res_q[idx_q];
    out_word_o.run_last = (ResCntW'(idx_q) + 1'b1 == cnt_q);
  end

  // Decode of one input word: results are pushed in order into res_d
  always_comb begin
    logic [7:0] b;
    logic       tok, skip;
    b      = in_q.data_byte;
    tok    = 1'b0;
    skip   = 1'b0;
    mode_d = mode_q;
    len_d  = len_q;
    ovf_d  = ovf_q;
    line_d = line_q;
    cnt_d  = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = '0;
    end

    if (in_q.end_of_input) begin
      unique case (mode_q)
        ModeToken, ModeQuoted: begin
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindEnd, token_byte: 8'h00,
            was_quoted: (mode_q == ModeQuoted), too_long: ovf_d,
            line_number: line_d, run_last: 1'b0};
          cnt_d = cnt_d + 1'b1;
        end
        ModeSlash: begin
          // held slash becomes a one-byte token; the limit is at least one
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindByte, token_byte: CharSlash,
            was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
          cnt_d = cnt_d + 1'b1;
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindEnd, token_byte: 8'h00,
            was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
          cnt_d = cnt_d + 1'b1;
        end
        default: begin
        end
      endcase
      res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindEoi, token_byte: 8'h00,
        was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
      cnt_d  = cnt_d + 1'b1;
      mode_d = ModeSkip;
      len_d  = '0;
      ovf_d  = 1'b0;
      line_d = '0;
    end else begin
      unique case (mode_q)
        ModeToken: tok = 1'b1;
        ModeQuoted: begin
          if (b == CharQuote) begin
            res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindEnd, token_byte: 8'h00,
              was_quoted: 1'b1, too_long: ovf_d, line_number: line_d, run_last: 1'b0};
            cnt_d  = cnt_d + 1'b1;
            mode_d = ModeSkip;
            len_d  = '0;
            ovf_d  = 1'b0;
          end else begin
            if (b == CharNl && line_d != '1) line_d = line_d + 1'b1;
            if (len_d < LenLimit) begin
              res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindByte, token_byte: b,
                was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
              cnt_d = cnt_d + 1'b1;
              len_d = len_d + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        ModeLineCmt: begin
          if (b == CharNl) begin
            if (line_d != '1) line_d = line_d + 1'b1;
            res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindBreak, token_byte: 8'h00,
              was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
            cnt_d  = cnt_d + 1'b1;
            mode_d = ModeSkip;
          end
        end
        ModeBlock: begin
          if (b == CharStar) begin
            mode_d = ModeStar;
          end else if (b == CharNl && line_d != '1) begin
            line_d = line_d + 1'b1;
          end
        end
        ModeStar: begin
          if (b == CharSlash) begin
            mode_d = ModeSkip;
          end else if (b != CharStar) begin
            if (b == CharNl && line_d != '1) line_d = line_d + 1'b1;
            mode_d = ModeBlock;
          end
        end
        ModeSlash: begin
          if (b == CharSlash) begin
            mode_d = ModeLineCmt;
          end else if (b == CharStar) begin
            mode_d = ModeBlock;
          end else begin
            // held slash opens a regular token, then b continues or ends that token
            res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindByte, token_byte: CharSlash,
              was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
            cnt_d  = cnt_d + 1'b1;
            len_d  = TokLenW'(1);
            ovf_d  = 1'b0;
            mode_d = ModeToken;
            tok    = 1'b1;
          end
        end
        default: begin
          mode_d = ModeSkip;
          skip   = 1'b1;
        end
      endcase

      if (tok) begin
        if (b <= CharSpace || b == CharSemi || b == CharLBrace || b == CharRBrace) begin
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindEnd, token_byte: 8'h00,
            was_quoted: 1'b0, too_long: ovf_d, line_number: line_d, run_last: 1'b0};
          cnt_d  = cnt_d + 1'b1;
          mode_d = ModeSkip;
          len_d  = '0;
          ovf_d  = 1'b0;
          skip   = 1'b1;
        end else if (len_d < LenLimit) begin
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindByte, token_byte: b,
            was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
          cnt_d = cnt_d + 1'b1;
          len_d = len_d + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end

      if (skip) begin
        priority if (b == CharNl) begin
          if (line_d != '1) line_d = line_d + 1'b1;
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindBreak, token_byte: 8'h00,
            was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
          cnt_d = cnt_d + 1'b1;
        end else if (b == CharSemi) begin
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindBreak, token_byte: 8'h00,
            was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
          cnt_d = cnt_d + 1'b1;
        end else if (b <= CharSpace) begin
          mode_d = mode_d;
        end else if (b == CharHash) begin
          mode_d = ModeLineCmt;
        end else if (b == CharSlash) begin
          mode_d = ModeSlash;
        end else if (b == CharQuote) begin
          mode_d = ModeQuoted;
          len_d  = '0;
          ovf_d  = 1'b0;
        end else if (b == CharLBrace || b == CharRBrace) begin
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindByte, token_byte: b,
            was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
          cnt_d = cnt_d + 1'b1;
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindEnd, token_byte: 8'h00,
            was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
          cnt_d = cnt_d + 1'b1;
        end else begin
          // start of a regular token; first byte always fits
          res_d[cnt_d[ResIdxW-1:0]] = '{result_kind: KindByte, token_byte: b,
            was_quoted: 1'b0, too_long: 1'b0, line_number: line_d, run_last: 1'b0};
          cnt_d  = cnt_d + 1'b1;
          mode_d = ModeToken;
          len_d  = TokLenW'(1);
          ovf_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
      mode_q    <= ModeSkip;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      line_q    <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
    end else begin
      if (in_take) begin
        in_full_q <= 1'b1;
      end else if (process) begin
        in_full_q <= 1'b0;
      end
      if (process) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        ovf_q  <= ovf_d;
        line_q <= line_d;
        cnt_q  <= cnt_d;
        idx_q  <= '0;
      end else if (last_take) begin
        cnt_q <= '0;
      end else if (out_take) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if (process) begin
      for (int i = 0; i < MaxResults; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

endmodule
